@@ rtl/core/bsfc_pkg.sv @@
// Shared types and constants for the bond stretch fracture check.
package bsfc_pkg;

  // Q8.24 weight times Q2.30 stretch: shift by 24 to return to Q2.30
  localparam int unsigned QShift   = 24;
  localparam int unsigned ValW     = 32;
  localparam int unsigned ProdW    = 2 * ValW + 1;
  localparam int unsigned ShW      = ProdW - QShift;
  localparam int unsigned DiffW    = ShW + 1;

  localparam logic [ValW-1:0]        AlphaReset = 32'h0040_0000;
  localparam logic signed [ValW-1:0] MaxReset   = 32'sd1;
  localparam logic signed [ValW-1:0] SatMax     = 32'sh7FFF_FFFF;
  localparam logic signed [ValW-1:0] SatMin     = 32'sh8000_0000;

  // Second-stage beat: decisions already made, scaled product pending subtract
  typedef struct packed {
    logic                   active;
    logic                   brk;
    logic                   intact_out;
    logic                   last;
    logic                   p_locked;
    logic signed [ShW-1:0]  prod_sh;
    logic signed [ValW-1:0] base;
  } bsfc_s2_t;

  // One result beat
  typedef struct packed {
    logic                   bond_intact_out;
    logic                   particle_done;
    logic                   crit_valid;
    logic signed [ValW-1:0] new_crit;
    logic                   broke_now;
  } bsfc_res_t;

endpackage

@@ rtl/core/bsfc_crit_acc.sv @@
// Running maximum and broken flag per particle, plus result formation.
module bsfc_crit_acc (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  bsfc_pkg::bsfc_s2_t  s2_i,
  output bsfc_pkg::bsfc_res_t res_o
);

  logic signed [bsfc_pkg::ValW-1:0]  running_max_q, running_max_d;
  logic                              any_broken_q, any_broken_d;
  logic signed [bsfc_pkg::DiffW-1:0] diff;
  logic signed [bsfc_pkg::ValW-1:0]  cand;
  logic signed [bsfc_pkg::ValW-1:0]  max_upd;
  logic                              brk_upd;
  logic                              report;

  // s00 minus scaled stretch, formed exactly then saturated to 32 bits
  assign diff = bsfc_pkg::DiffW'(s2_i.base) - bsfc_pkg::DiffW'(s2_i.prod_sh);

  always_comb begin
    if (diff > bsfc_pkg::DiffW'(bsfc_pkg::SatMax)) begin
      cand = bsfc_pkg::SatMax;
    end else if (diff < bsfc_pkg::DiffW'(bsfc_pkg::SatMin)) begin
      cand = bsfc_pkg::SatMin;
    end else begin
      cand = diff[bsfc_pkg::ValW-1:0];
    end
  end

  // Fold this bond into the particle's state
  always_comb begin
    max_upd = running_max_q;
    brk_upd = any_broken_q;
    if (s2_i.active) begin
      if (cand > running_max_q) begin
        max_upd = cand;
      end
      brk_upd = any_broken_q | s2_i.brk;
    end
  end

  // End of particle restores reset values
  always_comb begin
    running_max_d = running_max_q;
    any_broken_d  = any_broken_q;
    if (en_i) begin
      if (s2_i.last) begin
        running_max_d = bsfc_pkg::MaxReset;
        any_broken_d  = 1'b0;
      end else begin
        running_max_d = max_upd;
        any_broken_d  = brk_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_max_q <= bsfc_pkg::MaxReset;
      any_broken_q  <= 1'b0;
    end else begin
      running_max_q <= running_max_d;
      any_broken_q  <= any_broken_d;
    end
  end

  // Result fields; particle fields only on an unlocked last bond
  assign report = s2_i.last & ~s2_i.p_locked;

  always_comb begin
    res_o.bond_intact_out = s2_i.intact_out;
    res_o.particle_done   = s2_i.last;
    res_o.crit_valid      = report;
    res_o.new_crit        = report ? max_upd : '0;
    res_o.broke_now       = report & brk_upd;
  end

endmodule

@@ rtl/core/bond_stretch_fracture_check_top.sv @@
// Top level of the bond stretch fracture check: pipeline, weight register, ports.
// Throughput: one bond per cycle unless the result side stalls; three register
// stages (input, product, result) with per-stage ready so bubbles collapse and
// input is taken while a result waits. The 33x32 weight-by-stretch multiply sits
// alone between input and product stages. Reset (async, active low) empties all
// stages, sets alpha to 0.25 and max to the raw value 1 (one Q2.30 LSB).
module bond_stretch_fracture_check_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // weight register write
  input  logic        alpha_we_i,
  input  logic [31:0] alpha_i,
  // bond input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        particle_locked_i,
  input  logic signed [31:0] particle_crit_i,
  input  logic signed [31:0] neighbor_crit_i,
  input  logic        neighbor_locked_i,
  input  logic        bond_intact_i,
  input  logic signed [31:0] bond_stretch_i,
  input  logic signed [31:0] bond_base_crit_i,
  input  logic        last_bond_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        bond_intact_out_o,
  output logic        particle_done_o,
  output logic        crit_valid_o,
  output logic signed [31:0] new_crit_o,
  output logic        broke_now_o
);

  logic [bsfc_pkg::ValW-1:0] alpha_q, alpha_d;

  // stage 1: registered input beat
  logic                              s1_valid_q, s1_valid_d;
  logic                              s1_p_locked_q, s1_n_locked_q, s1_intact_q, s1_last_q;
  logic signed [bsfc_pkg::ValW-1:0]  s1_p_crit_q, s1_n_crit_q, s1_stretch_q, s1_base_q;

  // stage 2: product beat
  logic                              s2_valid_q, s2_valid_d;
  bsfc_pkg::bsfc_s2_t                s2_q, s2_d;

  // result register
  logic                              out_valid_q, out_valid_d;
  bsfc_pkg::bsfc_res_t               res_q, res_d;

  logic                              out_free, s2_ready, s1_ready;
  logic                              in_fire, s1_fire, s2_fire;
  logic signed [bsfc_pkg::ValW:0]    alpha_s;
  logic signed [bsfc_pkg::ProdW-1:0] prod;
  logic signed [bsfc_pkg::ValW-1:0]  lim;
  logic                              active;

  // Handshake chain, each stage fills when the one after it frees
  assign out_free   = ~out_valid_q | out_ready_i;
  assign s2_ready   = ~s2_valid_q | out_free;
  assign s1_ready   = ~s1_valid_q | s2_ready;
  assign in_ready_o = s1_ready;
  assign in_fire    = in_valid_i & s1_ready;
  assign s1_fire    = s1_valid_q & s2_ready;
  assign s2_fire    = s2_valid_q & out_free;

  // Weight register
  assign alpha_d = alpha_we_i ? alpha_i : alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= bsfc_pkg::AlphaReset;
    end else begin
      alpha_q <= alpha_d;
    end
  end

  // Stage valid bits
  assign s1_valid_d  = in_fire | (s1_valid_q & ~s2_ready);
  assign s2_valid_d  = s1_fire | (s2_valid_q & ~out_free);
  assign out_valid_d = s2_fire | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_p_locked_q <= particle_locked_i;
      s1_p_crit_q   <= particle_crit_i;
      s1_n_crit_q   <= neighbor_crit_i;
      s1_n_locked_q <= neighbor_locked_i;
      s1_intact_q   <= bond_intact_i;
      s1_stretch_q  <= bond_stretch_i;
      s1_base_q     <= bond_base_crit_i;
      s1_last_q     <= last_bond_i;
    end
  end

  // Break test and weighted stretch; floor shift is a plain drop of low bits
  assign alpha_s = {1'b0, alpha_q};
  assign prod    = bsfc_pkg::ProdW'(alpha_s) * bsfc_pkg::ProdW'(s1_stretch_q);
  assign lim     = (s1_p_crit_q < s1_n_crit_q) ? s1_p_crit_q : s1_n_crit_q;
  assign active  = ~s1_p_locked_q & ~s1_n_locked_q & s1_intact_q;

  always_comb begin
    s2_d.active     = active;
    s2_d.brk        = active & (s1_stretch_q > lim);
    s2_d.intact_out = s1_intact_q & ~(active & (s1_stretch_q > lim));
    s2_d.last       = s1_last_q;
    s2_d.p_locked   = s1_p_locked_q;
    s2_d.prod_sh    = prod[bsfc_pkg::ProdW-1:bsfc_pkg::QShift];
    s2_d.base       = s1_base_q;
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      s2_q <= s2_d;
    end
  end

  // Per-particle accumulation and result fields
  bsfc_crit_acc u_crit_acc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (s2_fire),
    .s2_i   (s2_q),
    .res_o  (res_d)
  );

  // Result register
  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign bond_intact_out_o = res_q.bond_intact_out;
  assign particle_done_o   = res_q.particle_done;
  assign crit_valid_o      = res_q.crit_valid;
  assign new_crit_o        = res_q.new_crit;
  assign broke_now_o       = res_q.broke_now;

endmodule

@@ sim/tb_top.sv @@
// Testbench for the bond stretch fracture check: directed and random bond streams against a local predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bsfc_pkg::*;

  localparam int          ClkHalf    = 6;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned MaxPrints  = 40;
  localparam int unsigned PhaseBonds = 300;
  localparam int unsigned NumPhases  = 5;
  localparam logic [31:0] AlphaMax   = 32'hFFFF_FFFF;

  // One bond beat as driven on the input channel
  typedef struct {
    logic               p_locked;
    logic signed [31:0] p_crit;
    logic signed [31:0] n_crit;
    logic               n_locked;
    logic               intact;
    logic signed [31:0] stretch;
    logic signed [31:0] base;
    logic               last;
  } bond_t;

  logic               clk_i;
  logic               rst_ni;
  logic               alpha_we_i;
  logic [31:0]        alpha_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               particle_locked_i;
  logic signed [31:0] particle_crit_i;
  logic signed [31:0] neighbor_crit_i;
  logic               neighbor_locked_i;
  logic               bond_intact_i;
  logic signed [31:0] bond_stretch_i;
  logic signed [31:0] bond_base_crit_i;
  logic               last_bond_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               bond_intact_out_o;
  logic               particle_done_o;
  logic               crit_valid_o;
  logic signed [31:0] new_crit_o;
  logic               broke_now_o;

  // Predictor state and result bookkeeping
  logic [31:0]        alpha_model = AlphaReset;
  logic signed [31:0] crit_max_model = MaxReset;
  logic               broke_model = 1'b0;
  bsfc_res_t          result_exp_q[$];
  int unsigned        mismatch_count = 0;
  int unsigned        results_seen = 0;
  int unsigned        cycle_count = 0;
  int unsigned        idle_pct = 35;
  int unsigned        stall_pct = 35;

  bond_stretch_fracture_check_top DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .alpha_we_i        (alpha_we_i),
    .alpha_i           (alpha_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .particle_locked_i (particle_locked_i),
    .particle_crit_i   (particle_crit_i),
    .neighbor_crit_i   (neighbor_crit_i),
    .neighbor_locked_i (neighbor_locked_i),
    .bond_intact_i     (bond_intact_i),
    .bond_stretch_i    (bond_stretch_i),
    .bond_base_crit_i  (bond_base_crit_i),
    .last_bond_i       (last_bond_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .bond_intact_out_o (bond_intact_out_o),
    .particle_done_o   (particle_done_o),
    .crit_valid_o      (crit_valid_o),
    .new_crit_o        (new_crit_o),
    .broke_now_o       (broke_now_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #(ClkHalf) clk_i = ~clk_i;
  end

  // Result-side backpressure, redrawn every cycle
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Predict one bond: breaking decision, running max update, end-of-particle report
  function automatic bsfc_res_t fracture_predict(input bond_t b);
    bsfc_res_t          r;
    logic signed [31:0] lim;
    longint             prod;
    longint             cand;
    r = '0;
    r.bond_intact_out = b.intact;
    if (!b.p_locked && !b.n_locked && b.intact) begin
      lim = (b.p_crit < b.n_crit) ? b.p_crit : b.n_crit;
      if (b.stretch > lim) begin
        r.bond_intact_out = 1'b0;
        broke_model = 1'b1;
      end
      // Q8.24 x Q2.30, floor back to Q2.30, then saturate the difference
      prod = longint'(alpha_model) * longint'(b.stretch);
      cand = longint'(b.base) - (prod >>> QShift);
      if (cand > longint'(SatMax)) cand = longint'(SatMax);
      if (cand < longint'(SatMin)) cand = longint'(SatMin);
      if (cand > longint'(crit_max_model)) crit_max_model = cand[31:0];
    end
    if (b.last) begin
      r.particle_done = 1'b1;
      if (!b.p_locked) begin
        r.crit_valid = 1'b1;
        r.new_crit   = crit_max_model;
        r.broke_now  = broke_model;
      end
      crit_max_model = MaxReset;
      broke_model    = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint want, input longint got);
    mismatch_count++;
    if (mismatch_count <= MaxPrints)
      $display("[%0t] result %0d: %s expected %0d, got %0d",
               $realtime, results_seen, what, want, got);
  endtask

  // Track accepted bonds and weight writes, check every accepted result beat
  always @(posedge clk_i) begin : result_monitor
    bond_t     b;
    bsfc_res_t want;
    cycle_count++;
    if (rst_ni) begin
      if (alpha_we_i) alpha_model = alpha_i;
      if (in_valid_i && in_ready_o) begin
        b.p_locked = particle_locked_i;
        b.p_crit   = particle_crit_i;
        b.n_crit   = neighbor_crit_i;
        b.n_locked = neighbor_locked_i;
        b.intact   = bond_intact_i;
        b.stretch  = bond_stretch_i;
        b.base     = bond_base_crit_i;
        b.last     = last_bond_i;
        result_exp_q.push_back(fracture_predict(b));
      end
      if (out_valid_o && out_ready_i) begin
        if (result_exp_q.size() == 0) begin
          report_mismatch("beat with nothing pending", 0, 1);
        end else begin
          want = result_exp_q.pop_front();
          if (bond_intact_out_o !== want.bond_intact_out)
            report_mismatch("bond_intact_out", want.bond_intact_out, bond_intact_out_o);
          if (particle_done_o !== want.particle_done)
            report_mismatch("particle_done", want.particle_done, particle_done_o);
          if (crit_valid_o !== want.crit_valid)
            report_mismatch("crit_valid", want.crit_valid, crit_valid_o);
          if (new_crit_o !== want.new_crit)
            report_mismatch("new_crit", want.new_crit, new_crit_o);
          if (broke_now_o !== want.broke_now)
            report_mismatch("broke_now", want.broke_now, broke_now_o);
        end
        results_seen++;
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CycleLimit) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d results pending", cycle_count,
             result_exp_q.size());
    $display("FAILED: results differ");
    $finish;
  end

  function automatic bond_t mk_bond(input logic pl, input logic signed [31:0] pc,
                                    input logic signed [31:0] nc, input logic nl,
                                    input logic intact, input logic signed [31:0] st,
                                    input logic signed [31:0] bs, input logic last);
    bond_t b;
    b.p_locked = pl;
    b.p_crit   = pc;
    b.n_crit   = nc;
    b.n_locked = nl;
    b.intact   = intact;
    b.stretch  = st;
    b.base     = bs;
    b.last     = last;
    return b;
  endfunction

  // Drive one bond beat, with random idle cycles ahead of it
  task automatic send_bond(input bond_t b);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    particle_locked_i <= b.p_locked;
    particle_crit_i   <= b.p_crit;
    neighbor_crit_i   <= b.n_crit;
    neighbor_locked_i <= b.n_locked;
    bond_intact_i     <= b.intact;
    bond_stretch_i    <= b.stretch;
    bond_base_crit_i  <= b.base;
    last_bond_i       <= b.last;
    in_valid_i        <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Stop sending and wait for the pipeline to empty
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (result_exp_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_alpha(input logic [31:0] value);
    drain_results();
    @(negedge clk_i);
    alpha_i    <= value;
    alpha_we_i <= 1'b1;
    @(negedge clk_i);
    alpha_we_i <= 1'b0;
  endtask

  // Q2.30 value: mostly within +-0.25, sometimes full range or a rail
  function automatic logic signed [31:0] pick_q230();
    case ($urandom_range(9))
      0, 1: return $urandom;
      2: return $urandom_range(1) ? SatMax : SatMin;
      default: return $signed($urandom_range(32'h2000_0000)) - 32'sh1000_0000;
    endcase
  endfunction

  // Stretch close to the breaking limit so both outcomes are common
  function automatic logic signed [31:0] near_limit(input logic signed [31:0] pc,
                                                    input logic signed [31:0] nc);
    logic signed [31:0] lim;
    longint             s;
    lim = (pc < nc) ? pc : nc;
    if ($urandom_range(99) < 15) return $urandom;
    s = longint'(lim) + longint'($urandom_range(64)) - 32;
    if (s > longint'(SatMax)) s = longint'(SatMax);
    if (s < longint'(SatMin)) s = longint'(SatMin);
    return s[31:0];
  endfunction

  // Break exactly above the limit, not at it; saturation on both rails; floor rounding
  task automatic test_breaking_edges();
    send_bond(mk_bond(1'b0, 32'sd100, 32'sd200, 1'b0, 1'b1, 32'sd100, 32'sd0, 1'b0));
    send_bond(mk_bond(1'b0, 32'sd100, 32'sd200, 1'b0, 1'b1, 32'sd101, 32'sd50000, 1'b1));
    send_bond(mk_bond(1'b0, SatMin, SatMax, 1'b0, 1'b1, SatMax, SatMin, 1'b1));
    send_bond(mk_bond(1'b0, SatMin, SatMin, 1'b0, 1'b1, SatMin, SatMax, 1'b1));
    send_bond(mk_bond(1'b0, 32'sd0, 32'sd0, 1'b0, 1'b1, -32'sd1, 32'sd5, 1'b1));
  endtask

  // Locked neighbor, broken bond, locked owner, mixed lock flags, state reset
  task automatic test_skipped_bonds();
    send_bond(mk_bond(1'b0, 32'sd0, 32'sd0, 1'b1, 1'b1, SatMax, SatMax, 1'b0));
    send_bond(mk_bond(1'b0, 32'sd0, 32'sd0, 1'b0, 1'b0, SatMax, SatMax, 1'b0));
    send_bond(mk_bond(1'b0, 32'sd1000, 32'sd1000, 1'b0, 1'b1, 32'sd0, 32'sd7, 1'b1));
    send_bond(mk_bond(1'b1, 32'sd0, 32'sd0, 1'b0, 1'b1, SatMax, SatMax, 1'b0));
    send_bond(mk_bond(1'b1, 32'sd0, 32'sd0, 1'b0, 1'b1, SatMax, SatMax, 1'b1));
    send_bond(mk_bond(1'b1, 32'sd0, 32'sd0, 1'b0, 1'b1, SatMax, SatMax, 1'b0));
    send_bond(mk_bond(1'b0, 32'sd0, 32'sd0, 1'b0, 1'b1, 32'sd10, 32'sd1000, 1'b0));
    send_bond(mk_bond(1'b1, 32'sd0, 32'sd0, 1'b0, 1'b1, 32'sd10, 32'sd2000, 1'b1));
    send_bond(mk_bond(1'b0, 32'sd5, 32'sd5, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b1));
  endtask

  // Weight at zero, at its top value and at the smallest step
  task automatic test_alpha_extremes();
    set_alpha(32'h0);
    send_bond(mk_bond(1'b0, SatMax, SatMax, 1'b0, 1'b1, SatMin, 32'sd123, 1'b1));
    set_alpha(AlphaMax);
    send_bond(mk_bond(1'b0, SatMax, SatMax, 1'b0, 1'b1, SatMax, SatMax, 1'b0));
    send_bond(mk_bond(1'b0, SatMax, SatMax, 1'b0, 1'b1, SatMin, SatMin, 1'b1));
    set_alpha(32'h1);
    send_bond(mk_bond(1'b0, SatMax, SatMax, 1'b0, 1'b1, -32'sd1, 32'sd9, 1'b1));
  endtask

  // One particle of random size; a few are locked or carry mixed lock flags
  task automatic send_random_particle(output int unsigned count);
    int unsigned        n;
    int unsigned        kind;
    logic signed [31:0] own_crit;
    bond_t              b;
    n = $urandom_range(8, 1);
    if ($urandom_range(99) < 5) n = $urandom_range(24, 9);
    kind = $urandom_range(99);
    own_crit = pick_q230();
    for (int unsigned k = 0; k < n; k++) begin
      if (kind < 8) b.p_locked = 1'b1;
      else if (kind < 14) b.p_locked = 1'($urandom_range(1));
      else b.p_locked = 1'b0;
      b.p_crit   = ($urandom_range(99) < 10) ? pick_q230() : own_crit;
      b.n_crit   = pick_q230();
      b.n_locked = ($urandom_range(99) < 12);
      b.intact   = ($urandom_range(99) < 85);
      b.stretch  = near_limit(b.p_crit, b.n_crit);
      b.base     = pick_q230();
      b.last     = (k == n - 1);
      send_bond(b);
    end
    count = n;
  endtask

  // Random particles over several weight settings; the middle phase runs without gaps
  task automatic test_random_particles();
    logic [31:0] alpha_pick[NumPhases];
    int unsigned phase_bonds;
    int unsigned n;
    alpha_pick[0] = AlphaReset;
    alpha_pick[1] = 32'h0;
    alpha_pick[2] = AlphaMax;
    alpha_pick[3] = $urandom;
    alpha_pick[4] = $urandom_range(32'h0200_0000);
    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      set_alpha(alpha_pick[ph]);
      idle_pct  = (ph == 2) ? 0 : 35;
      stall_pct = idle_pct;
      phase_bonds = 0;
      while (phase_bonds < PhaseBonds) begin
        send_random_particle(n);
        phase_bonds += n;
      end
    end
    idle_pct  = 35;
    stall_pct = 35;
  endtask

  initial begin
    rst_ni            = 1'b0;
    alpha_we_i        = 1'b0;
    alpha_i           = '0;
    in_valid_i        = 1'b0;
    particle_locked_i = 1'b0;
    particle_crit_i   = '0;
    neighbor_crit_i   = '0;
    neighbor_locked_i = 1'b0;
    bond_intact_i     = 1'b0;
    bond_stretch_i    = '0;
    bond_base_crit_i  = '0;
    last_bond_i       = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_breaking_edges();
    test_skipped_bonds();
    test_alpha_extremes();
    test_random_particles();

    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/bsfc_pkg.sv
rtl/core/bsfc_crit_acc.sv
rtl/core/bond_stretch_fracture_check_top.sv
sim/tb_top.sv
